@@ design/imudr_pkg.sv @@
// ============================================================================
// imudr_pkg
// Shared types, operation codes and constants of the dead-reckoning integrator.
// ============================================================================
package imudr_pkg;

    // Default number of CORDIC rotations.
    localparam int CORDIC_STEPS_DEF = 16;

    // Width of the sequencer index (covers axes, reduction steps and up to 32
    // CORDIC rotations).
    localparam int IDX_W = 5;

    // Configuration register indexes.
    localparam logic [1:0] REG_TIME_STEP = 2'd0;
    localparam logic [1:0] REG_MAX_VEL   = 2'd1;
    localparam logic [1:0] REG_DAMPING   = 2'd2;
    localparam logic [1:0] REG_GRAVITY   = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] TIME_STEP_RST = 16'd655;
    localparam logic [30:0] MAX_VEL_RST   = 31'd655360;
    localparam logic [15:0] DAMPING_RST   = 16'd64881;
    localparam logic [14:0] GRAVITY_RST   = 15'd2511;

    // Sequencer operation codes; the controller also uses them as its states.
    localparam logic [4:0] OP_NOP      = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_ANG_MUL  = 5'd2;
    localparam logic [4:0] OP_ANG_UPD  = 5'd3;
    localparam logic [4:0] OP_RED_INIT = 5'd4;
    localparam logic [4:0] OP_RED_STEP = 5'd5;
    localparam logic [4:0] OP_FOLD     = 5'd6;
    localparam logic [4:0] OP_CORDIC   = 5'd7;
    localparam logic [4:0] OP_ACC_MUL1 = 5'd8;
    localparam logic [4:0] OP_ACC_MUL2 = 5'd9;
    localparam logic [4:0] OP_ACC_FIN  = 5'd10;
    localparam logic [4:0] OP_ACC_Z    = 5'd11;
    localparam logic [4:0] OP_V_MUL1   = 5'd12;
    localparam logic [4:0] OP_V_ADD    = 5'd13;
    localparam logic [4:0] OP_V_MUL2   = 5'd14;
    localparam logic [4:0] OP_V_DAMP   = 5'd15;
    localparam logic [4:0] OP_P_MUL    = 5'd16;
    localparam logic [4:0] OP_P_UPD    = 5'd17;
    localparam logic [4:0] OP_DONE     = 5'd18;

    // Sequencer index limits.
    localparam logic [IDX_W-1:0] AXIS_LAST  = 5'd2;
    localparam logic [IDX_W-1:0] PLANE_LAST = 5'd1;
    localparam logic [IDX_W-1:0] RED_TOP    = 5'd8;

    // Angle constants in Q16.16 degrees.
    localparam logic [33:0] DEG360_34   = 34'd23592960;
    localparam logic [33:0] RED_BIAS    = 34'd3019898880;   // 128 turns
    localparam logic signed [25:0] DEG360_S = 26'sd23592960;
    localparam logic signed [25:0] DEG180_S = 26'sd11796480;
    localparam logic signed [25:0] DEG90_S  = 26'sd5898240;

    // CORDIC start value (inverse gain, Q2.30).
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic [4:0]       op;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] roll_deg;
        logic signed [31:0] pitch_deg;
        logic signed [31:0] yaw_deg;
    } out_t;

    // Arctangent of 2^-i in Q16.16 degrees.
    function automatic logic [21:0] atan_deg(input logic [IDX_W-1:0] i);
        logic [21:0] r;
        unique case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/imudr_ctrl.sv @@
// ============================================================================
// imudr_ctrl
// Sequencer that walks one sample through the shared datapath.
// ============================================================================
module imudr_ctrl #(
    parameter int CORDIC_STEPS = imudr_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output imudr_pkg::cmd_t   cmd
);

    localparam logic [imudr_pkg::IDX_W-1:0] CORDIC_LAST =
        imudr_pkg::IDX_W'(CORDIC_STEPS - 1);

    logic [4:0]                  state_reg, state_next;
    logic [imudr_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic                        m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = state_reg;
        cmd.idx    = cnt_reg;
        unique case (state_reg)
            imudr_pkg::OP_NOP: begin
                cmd.op = s_valid ? imudr_pkg::OP_LOAD : imudr_pkg::OP_NOP;
                if (s_valid) begin
                    state_next = imudr_pkg::OP_ANG_MUL;
                    cnt_next   = '0;
                end
            end
            imudr_pkg::OP_ANG_MUL: state_next = imudr_pkg::OP_ANG_UPD;
            imudr_pkg::OP_ANG_UPD: begin
                if (cnt_reg == imudr_pkg::AXIS_LAST) begin
                    state_next = imudr_pkg::OP_RED_INIT;
                    cnt_next   = imudr_pkg::RED_TOP;
                end else begin
                    state_next = imudr_pkg::OP_ANG_MUL;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            imudr_pkg::OP_RED_INIT: state_next = imudr_pkg::OP_RED_STEP;
            imudr_pkg::OP_RED_STEP: begin
                if (cnt_reg == '0) begin
                    state_next = imudr_pkg::OP_FOLD;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            imudr_pkg::OP_FOLD: begin
                state_next = imudr_pkg::OP_CORDIC;
                cnt_next   = '0;
            end
            imudr_pkg::OP_CORDIC: begin
                if (cnt_reg == CORDIC_LAST) begin
                    state_next = imudr_pkg::OP_ACC_MUL1;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            imudr_pkg::OP_ACC_MUL1: state_next = imudr_pkg::OP_ACC_MUL2;
            imudr_pkg::OP_ACC_MUL2: state_next = imudr_pkg::OP_ACC_FIN;
            imudr_pkg::OP_ACC_FIN: begin
                if (cnt_reg == imudr_pkg::PLANE_LAST) begin
                    state_next = imudr_pkg::OP_ACC_Z;
                end else begin
                    state_next = imudr_pkg::OP_ACC_MUL1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            imudr_pkg::OP_ACC_Z: begin
                state_next = imudr_pkg::OP_V_MUL1;
                cnt_next   = '0;
            end
            imudr_pkg::OP_V_MUL1: state_next = imudr_pkg::OP_V_ADD;
            imudr_pkg::OP_V_ADD:  state_next = imudr_pkg::OP_V_MUL2;
            imudr_pkg::OP_V_MUL2: state_next = imudr_pkg::OP_V_DAMP;
            imudr_pkg::OP_V_DAMP: state_next = imudr_pkg::OP_P_MUL;
            imudr_pkg::OP_P_MUL:  state_next = imudr_pkg::OP_P_UPD;
            imudr_pkg::OP_P_UPD: begin
                if (cnt_reg == imudr_pkg::AXIS_LAST) begin
                    state_next = imudr_pkg::OP_DONE;
                end else begin
                    state_next = imudr_pkg::OP_V_MUL1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            imudr_pkg::OP_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = imudr_pkg::OP_NOP;
                end else begin
                    cmd.op = imudr_pkg::OP_NOP;
                end
            end
            default: state_next = imudr_pkg::OP_NOP;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (cmd.op == imudr_pkg::OP_DONE) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= imudr_pkg::OP_NOP;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == imudr_pkg::OP_NOP);
    assign m_valid = m_valid_reg;

    // An accepted sample always starts with the roll rate product.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == imudr_pkg::OP_ANG_MUL && cnt_reg == '0))
        else $error("sequence did not start at the first angle step");

    // The rotation counter never runs past the configured step count.
    a_cordic_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imudr_pkg::OP_CORDIC) |-> (cnt_reg <= CORDIC_LAST))
        else $error("CORDIC counter out of range");

    // The reduction never shifts the turn constant past its top step.
    a_red_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imudr_pkg::OP_RED_STEP) |-> (cnt_reg <= imudr_pkg::RED_TOP))
        else $error("reduction counter out of range");

    // A new result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == imudr_pkg::OP_DONE) |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

endmodule

@@ design/imudr_datapath.sv @@
// ============================================================================
// imudr_datapath
// State stores, configuration, shared multiplier, angle reduction, CORDIC and the state updates.
// ============================================================================
module imudr_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  imudr_pkg::cmd_t  cmd,
    input  imudr_pkg::in_t   s_data,
    output imudr_pkg::out_t  m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [30:0]      cfg_wdata
);

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Configuration.
    logic [15:0] time_step_reg;
    logic [30:0] max_vel_reg;
    logic [15:0] damping_reg;
    logic [14:0] gravity_reg;

    // Architectural state.
    logic signed [31:0] angle_reg [3];
    logic signed [31:0] angle_next [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_next [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [17:0] prev_reg [3];
    logic signed [17:0] prev_next [3];

    // Working registers.
    imudr_pkg::in_t     in_reg, in_next;
    imudr_pkg::out_t    out_reg, out_next;
    logic signed [17:0] cur_reg [3];
    logic signed [17:0] cur_next [3];
    logic signed [49:0] p_reg, p_next;
    logic signed [49:0] acc_reg, acc_next;
    logic signed [32:0] v_reg, v_next;
    logic [33:0]        t_reg, t_next;
    logic signed [24:0] z_reg, z_next;
    logic signed [32:0] x_reg, x_next;
    logic signed [32:0] y_reg, y_next;
    logic               flip_reg, flip_next;

    logic [1:0]         k;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [16:0] ts_b;
    logic signed [32:0] cos_v, sin_v;
    logic signed [15:0] rate_k;
    logic signed [49:0] rnd6, rnd9, rnd16;
    logic signed [50:0] plane_sum, rnd30;
    logic signed [33:0] lim34, vd;
    logic [33:0]        red_sub;
    logic signed [25:0] tz, hz;
    logic signed [32:0] xs, ys;
    logic signed [24:0] at;
    logic signed [18:0] asum;

    assign k     = cmd.idx[1:0];
    assign ts_b  = $signed({1'b0, time_step_reg});
    assign cos_v = flip_reg ? -x_reg : x_reg;
    assign sin_v = flip_reg ? -y_reg : y_reg;

    always_comb begin
        unique case (k)
            2'd0:    rate_k = in_reg.rate_x;
            2'd1:    rate_k = in_reg.rate_y;
            default: rate_k = in_reg.rate_z;
        endcase
    end

    assign asum = 19'(prev_reg[k]) + 19'(cur_reg[k]);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            imudr_pkg::OP_ANG_MUL: begin
                mul_a = 33'(rate_k);
                mul_b = ts_b;
            end
            imudr_pkg::OP_ACC_MUL1: begin
                mul_a = (k == 2'd0) ? cos_v : sin_v;
                mul_b = 17'(in_reg.accel_x);
            end
            imudr_pkg::OP_ACC_MUL2: begin
                mul_a = (k == 2'd0) ? sin_v : cos_v;
                mul_b = 17'(in_reg.accel_y);
            end
            imudr_pkg::OP_V_MUL1: begin
                mul_a = 33'(asum);
                mul_b = ts_b;
            end
            imudr_pkg::OP_V_MUL2: begin
                mul_a = v_reg;
                mul_b = $signed({1'b0, damping_reg});
            end
            imudr_pkg::OP_P_MUL: begin
                mul_a = 33'(vel_reg[k]);
                mul_b = ts_b;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p_next = mul_a * mul_b;

    // Round-half-up scalings of the last product and of the plane sum.
    assign rnd6  = (p_reg + 50'sd32) >>> 6;
    assign rnd9  = (p_reg + 50'sd256) >>> 9;
    assign rnd16 = (p_reg + 50'sd32768) >>> 16;
    assign plane_sum = (k == 2'd0) ? (51'(acc_reg) - 51'(p_reg))
                                   : (51'(acc_reg) + 51'(p_reg));
    assign rnd30 = (plane_sum + 51'sd536870912) >>> 30;

    assign lim34   = $signed({3'b000, max_vel_reg});
    assign red_sub = imudr_pkg::DEG360_34 << cmd.idx;
    assign tz      = $signed({1'b0, t_reg[24:0]});
    assign hz      = (tz >= imudr_pkg::DEG180_S) ? (tz - imudr_pkg::DEG360_S) : tz;
    assign xs      = x_reg >>> cmd.idx;
    assign ys      = y_reg >>> cmd.idx;
    assign at      = $signed({3'b000, imudr_pkg::atan_deg(cmd.idx)});

    always_comb begin
        if ($signed(rnd16[33:0]) > lim34) begin
            vd = lim34;
        end else if ($signed(rnd16[33:0]) < -lim34) begin
            vd = -lim34;
        end else begin
            vd = $signed(rnd16[33:0]);
        end
    end

    always_comb begin
        angle_next = angle_reg;
        vel_next   = vel_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        in_next    = in_reg;
        out_next   = out_reg;
        acc_next   = acc_reg;
        v_next     = v_reg;
        t_next     = t_reg;
        z_next     = z_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        flip_next  = flip_reg;
        unique case (cmd.op)
            imudr_pkg::OP_LOAD: in_next = s_data;
            imudr_pkg::OP_ANG_UPD: begin
                angle_next[k] = sat32(34'(angle_reg[k]) + rnd6[33:0]);
            end
            imudr_pkg::OP_RED_INIT: begin
                t_next = 34'(angle_reg[2]) + imudr_pkg::RED_BIAS;
            end
            imudr_pkg::OP_RED_STEP: begin
                if (t_reg >= red_sub) begin
                    t_next = t_reg - red_sub;
                end
            end
            imudr_pkg::OP_FOLD: begin
                x_next = imudr_pkg::CORDIC_GAIN;
                y_next = '0;
                if (hz > imudr_pkg::DEG90_S) begin
                    z_next    = 25'(hz - imudr_pkg::DEG180_S);
                    flip_next = 1'b1;
                end else if (hz < -imudr_pkg::DEG90_S) begin
                    z_next    = 25'(hz + imudr_pkg::DEG180_S);
                    flip_next = 1'b1;
                end else begin
                    z_next    = hz[24:0];
                    flip_next = 1'b0;
                end
            end
            imudr_pkg::OP_CORDIC: begin
                if (!z_reg[24]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + at;
                end
            end
            imudr_pkg::OP_ACC_MUL2: acc_next = p_reg;
            imudr_pkg::OP_ACC_FIN:  cur_next[k] = rnd30[17:0];
            imudr_pkg::OP_ACC_Z: begin
                cur_next[2] = 18'(in_reg.accel_z) - $signed({3'b000, gravity_reg});
            end
            imudr_pkg::OP_V_ADD: begin
                v_next       = 33'(vel_reg[k]) + rnd9[32:0];
                prev_next[k] = cur_reg[k];
            end
            imudr_pkg::OP_V_DAMP: vel_next[k] = vd[31:0];
            imudr_pkg::OP_P_UPD: begin
                pos_next[k] = sat32(34'(pos_reg[k]) + rnd16[33:0]);
            end
            imudr_pkg::OP_DONE: begin
                out_next.pos_x     = pos_reg[0];
                out_next.pos_y     = pos_reg[1];
                out_next.pos_z     = pos_reg[2];
                out_next.vel_x     = vel_reg[0];
                out_next.vel_y     = vel_reg[1];
                out_next.vel_z     = vel_reg[2];
                out_next.roll_deg  = angle_reg[0];
                out_next.pitch_deg = angle_reg[1];
                out_next.yaw_deg   = angle_reg[2];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= imudr_pkg::TIME_STEP_RST;
            max_vel_reg   <= imudr_pkg::MAX_VEL_RST;
            damping_reg   <= imudr_pkg::DAMPING_RST;
            gravity_reg   <= imudr_pkg::GRAVITY_RST;
            angle_reg     <= '{default: '0};
            vel_reg       <= '{default: '0};
            pos_reg       <= '{default: '0};
            prev_reg      <= '{default: '0};
        end else begin
            angle_reg <= angle_next;
            vel_reg   <= vel_next;
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    imudr_pkg::REG_TIME_STEP: time_step_reg <= cfg_wdata[15:0];
                    imudr_pkg::REG_MAX_VEL:   max_vel_reg   <= cfg_wdata;
                    imudr_pkg::REG_DAMPING:   damping_reg   <= cfg_wdata[15:0];
                    imudr_pkg::REG_GRAVITY:   gravity_reg   <= cfg_wdata[14:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        out_reg  <= out_next;
        cur_reg  <= cur_next;
        p_reg    <= p_next;
        acc_reg  <= acc_next;
        v_reg    <= v_next;
        t_reg    <= t_next;
        z_reg    <= z_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        flip_reg <= flip_next;
    end

    assign m_data = out_reg;

endmodule

@@ design/imu_dead_reckoning_integrator_top.sv @@
// ============================================================================
// imu_dead_reckoning_integrator_top
// Strapdown dead-reckoning integrator: angles, yaw-rotated acceleration,
// damped and clamped velocity, and position, all in fixed point.
// ============================================================================
//
//  Channel  Direction  Handshake           Beat contents
//  s_       in         s_valid / s_ready   one IMU sample (in_t)
//  m_       out        m_valid / m_ready   nine state values (out_t)
//  cfg_     in         cfg_we              register index and write data
//
// A sample occupies the block from its accept until the sequencer returns to
// idle, and no new sample is accepted before that; the result register is
// loaded in the final step. The sequence is bound by the single shared
// 33x17 multiplier (16 products), a nine-step restoring reduction of yaw
// modulo one turn, and one CORDIC rotation a cycle.
// Reset is synchronous and active low; it restores the register defaults and
// clears all angles, velocities, positions and the stored acceleration.
// The result register decouples the output: the next sample is accepted while
// a result beat waits, and only the final load waits for m_ready.
// Configuration writes take effect at once and are meant for idle periods.
//
module imu_dead_reckoning_integrator_top #(
    parameter int CORDIC_STEPS = imudr_pkg::CORDIC_STEPS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  imudr_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output imudr_pkg::out_t  m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [30:0]      cfg_wdata
);

    // Command from the sequencer to the datapath, one operation per cycle.
    imudr_pkg::cmd_t cmd;

    imudr_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds all state, so the result is the stores themselves,
    // copied into the output register at the end of the sequence.
    imudr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
